FILE: rtl/core/fen_pkg.sv
package fen_pkg;

    localparam int SIZE   = 1024;
    localparam int IDX_W  = $clog2(SIZE);
    localparam int WALK_W = IDX_W + 1;
    localparam int CELL_W = 32;
    // Signed accumulator: headroom for one cell per tree level plus a sign bit
    localparam int ACC_W  = CELL_W + $clog2(IDX_W + 1) + 1;

    localparam logic [CELL_W-1:0] CELL_MAX = '1;

    localparam logic [1:0] OP_INC   = 2'd0;
    localparam logic [1:0] OP_RANGE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        DP_HOLD,
        DP_ZERO,
        DP_ADD,
        DP_SUB,
        DP_INC
    } dp_cmd_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

endpackage

FILE: rtl/core/fen_mem.sv
module fen_mem (
    input  logic                      clk,
    input  fen_pkg::mem_req_t         req,
    output logic [fen_pkg::CELL_W-1:0] rdata
);
    import fen_pkg::*;

    logic [CELL_W-1:0] cells [SIZE];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            cells[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= cells[req.raddr];
        end
    end

endmodule

FILE: rtl/core/fen_alu.sv
module fen_alu (
    input  logic                       clk,
    input  logic                       rst_n,
    input  fen_pkg::dp_cmd_t           cmd,
    input  logic [fen_pkg::CELL_W-1:0] rdata,
    output logic [fen_pkg::CELL_W-1:0] inc_value,
    output logic [fen_pkg::CELL_W-1:0] total
);
    import fen_pkg::*;

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [ACC_W-1:0] opa;
    logic [ACC_W-1:0] opb;
    logic             cin;
    logic [ACC_W-1:0] sum;

    // One shared adder: cell + 1 for increments, acc +/- cell for prefix walks
    always_comb
    begin
        opa = acc_reg;
        opb = '0;
        cin = 1'b0;
        case (cmd)
            DP_ADD:
            begin
                opb = ACC_W'(rdata);
            end
            DP_SUB:
            begin
                opb = ~ACC_W'(rdata);
                cin = 1'b1;
            end
            DP_INC:
            begin
                opa = ACC_W'(rdata);
                cin = 1'b1;
            end
            default:
            begin
                opb = '0;
            end
        endcase
        sum = opa + opb + ACC_W'(cin);
    end

    assign inc_value = (rdata == CELL_MAX) ? rdata : sum[CELL_W-1:0];

    always_comb
    begin
        case (cmd) inside
            DP_ZERO:           acc_next = '0;
            DP_ADD, DP_SUB:    acc_next = sum;
            default:           acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    // Floor at zero, saturate at the cell maximum
    always_comb
    begin
        if (acc_reg[ACC_W-1])
        begin
            total = '0;
        end
        else if (acc_reg[ACC_W-2:CELL_W] != '0)
        begin
            total = CELL_MAX;
        end
        else
        begin
            total = acc_reg[CELL_W-1:0];
        end
    end

endmodule

FILE: rtl/core/fen_ctrl.sv
module fen_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  logic [1:0]                 operation,
    input  logic [10:0]                first_index,
    input  logic [9:0]                 last_index,
    output logic                       range_valid,
    input  logic                       range_ready,
    output logic [fen_pkg::CELL_W-1:0] range_total,
    output fen_pkg::mem_req_t          mem_req,
    output fen_pkg::dp_cmd_t           dp_cmd,
    input  logic [fen_pkg::CELL_W-1:0] inc_value,
    input  logic [fen_pkg::CELL_W-1:0] total
);
    import fen_pkg::*;

    typedef enum logic [6:0] {
        ST_CLEAR   = 7'b0000001,
        ST_IDLE    = 7'b0000010,
        ST_INC_RD  = 7'b0000100,
        ST_INC_WR  = 7'b0001000,
        ST_QRY_RD  = 7'b0010000,
        ST_QRY_ACC = 7'b0100000,
        ST_FIN     = 7'b1000000
    } state_t;

    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(SIZE - 1);

    state_t            state_reg, state_next;
    logic [WALK_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0]  lower_reg, lower_next;
    logic              phase_reg, phase_next;
    logic [IDX_W-1:0]  clr_addr_reg, clr_addr_next;
    logic              out_valid_reg, out_valid_next;
    logic [CELL_W-1:0] out_total_reg, out_total_next;

    logic              accept;
    logic [31:0]       first_ext;
    logic [31:0]       last_ext;
    logic [31:0]       first_m1;
    logic [IDX_W-1:0]  upper_idx;
    logic [IDX_W-1:0]  lower_idx;
    logic [WALK_W-1:0] k_up;
    logic [WALK_W-1:0] k_down;

    assign req_ready   = (state_reg == ST_IDLE);
    assign accept      = req_valid && req_ready;
    assign range_valid = out_valid_reg;
    assign range_total = out_total_reg;

    assign first_ext = 32'(first_index);
    assign last_ext  = 32'(last_index);
    assign first_m1  = first_ext - 32'd1;
    assign upper_idx = (last_ext > 32'(SIZE - 1)) ? LAST_ADDR : IDX_W'(last_ext);
    assign lower_idx = (first_ext == 32'd0) ? '0 :
                       (first_m1 > 32'(SIZE - 1)) ? LAST_ADDR : IDX_W'(first_m1);

    // Upward step adds the lowest set bit, downward step clears it
    assign k_up   = k_reg + (k_reg & (~k_reg + WALK_W'(1)));
    assign k_down = k_reg & (k_reg - WALK_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        lower_next     = lower_reg;
        phase_next     = phase_reg;
        clr_addr_next  = clr_addr_reg;
        out_valid_next = out_valid_reg;
        out_total_next = out_total_reg;
        mem_req        = '0;
        dp_cmd         = DP_HOLD;

        if (out_valid_reg && range_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_addr_reg;
                mem_req.wdata = '0;
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        OP_INC:
                        begin
                            if (first_ext != 32'd0 && first_ext < 32'(SIZE))
                            begin
                                k_next     = WALK_W'(first_index);
                                state_next = ST_INC_RD;
                            end
                        end
                        OP_RANGE:
                        begin
                            dp_cmd = DP_ZERO;
                            if (first_ext > last_ext)
                            begin
                                state_next = ST_FIN;
                            end
                            else
                            begin
                                k_next     = WALK_W'(upper_idx);
                                lower_next = lower_idx;
                                phase_next = 1'b0;
                                state_next = ST_QRY_RD;
                            end
                        end
                        OP_CLEAR:
                        begin
                            clr_addr_next = '0;
                            state_next    = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_INC_RD:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = k_reg[IDX_W-1:0];
                state_next    = ST_INC_WR;
            end
            ST_INC_WR:
            begin
                dp_cmd        = DP_INC;
                mem_req.we    = 1'b1;
                mem_req.waddr = k_reg[IDX_W-1:0];
                mem_req.wdata = inc_value;
                k_next        = k_up;
                state_next    = (k_up >= WALK_W'(SIZE)) ? ST_IDLE : ST_INC_RD;
            end
            ST_QRY_RD:
            begin
                if (k_reg == '0)
                begin
                    if (!phase_reg)
                    begin
                        phase_next = 1'b1;
                        k_next     = WALK_W'(lower_reg);
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = k_reg[IDX_W-1:0];
                    state_next    = ST_QRY_ACC;
                end
            end
            ST_QRY_ACC:
            begin
                dp_cmd     = phase_reg ? DP_SUB : DP_ADD;
                k_next     = k_down;
                state_next = ST_QRY_RD;
            end
            ST_FIN:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || range_ready)
                begin
                    out_valid_next = 1'b1;
                    out_total_next = total;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            k_reg         <= '0;
            lower_reg     <= '0;
            phase_reg     <= 1'b0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            lower_reg     <= lower_next;
            phase_reg     <= phase_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_total_reg <= out_total_next;
    end

endmodule

FILE: rtl/core/fenwick_range_counter.sv
// Increment: each tree level walked upward is read, then written back (INC_RD, INC_WR).
// Range count: walks down from last adding cells, then down from first-1 subtracting them;
// range_valid follows (first-1 taken as 0 when first is 0; an inverted range skips both).
// Clear: one cell written per cycle through the single write port.
// One transaction at a time; rate set by the one memory read port and shared adder.
// Reset starts a clearing pass over all SIZE (1024) cells; req_ready stays low until it ends.
module fenwick_range_counter (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  logic [1:0]                 operation,
    input  logic [10:0]                first_index,
    input  logic [9:0]                 last_index,
    output logic                       range_valid,
    input  logic                       range_ready,
    output logic [fen_pkg::CELL_W-1:0] range_total
);
    import fen_pkg::*;

    mem_req_t          mem_req;
    dp_cmd_t           dp_cmd;
    logic [CELL_W-1:0] rdata;
    logic [CELL_W-1:0] inc_value;
    logic [CELL_W-1:0] total;

    fen_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .operation   (operation),
        .first_index (first_index),
        .last_index  (last_index),
        .range_valid (range_valid),
        .range_ready (range_ready),
        .range_total (range_total),
        .mem_req     (mem_req),
        .dp_cmd      (dp_cmd),
        .inc_value   (inc_value),
        .total       (total)
    );

    fen_alu u_alu (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .rdata     (rdata),
        .inc_value (inc_value),
        .total     (total)
    );

    fen_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

endmodule

FILE: rtl/core/fen_checker.sv
module fen_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic [1:0]                 operation,
    input logic                       range_valid,
    input logic                       range_ready,
    input logic [fen_pkg::CELL_W-1:0] range_total
);
    import fen_pkg::*;

    // Clearing pass blocks new transactions right after reset
    assert property (@(posedge clk) $rose(rst_n) |-> !req_ready)
        else $error("req_ready high during the post-reset clearing pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && operation == OP_CLEAR) |=> !req_ready)
        else $error("clear transaction did not start a clearing pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && operation == OP_RANGE) |=> !req_ready)
        else $error("range count accepted without a busy walk");

    assert property (@(posedge clk) disable iff (!rst_n)
        (range_valid && !range_ready) |=> (range_valid && $stable(range_total)))
        else $error("stalled result dropped or changed");

endmodule

bind fenwick_range_counter fen_checker u_fen_checker (.*);
